FILE: rtl/fast_inverse_sqrt_macros.svh
// Assertion macros used by the fast inverse square root top level.
`ifndef FAST_INVERSE_SQRT_MACROS_SVH
`define FAST_INVERSE_SQRT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FISQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FISQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fisq_pkg.sv
// Package: constants, types and helper functions for the inverse square root pipeline.
`default_nettype none
package fisq_pkg;

  localparam logic [31:0] FISQ_MAGIC     = 32'h5f3759df;
  localparam logic [31:0] FISQ_CANON_NAN = 32'h7FC00000;
  localparam logic [31:0] FISQ_HALF      = 32'h3F000000;
  localparam logic [31:0] FISQ_ONE_HALF  = 32'h3FC00000;
  localparam logic [7:0]  FISQ_EXP_MAX   = 8'hFF;

  typedef struct packed {
    logic signed [10:0] exp;
    logic [23:0]        mant;
  } fisq_unpk_t;

  function automatic logic [4:0] fisq_lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  function automatic fisq_unpk_t fisq_unpack_norm(input logic [30:0] mag);
    fisq_unpk_t u;
    logic [23:0] m;
    logic [4:0]  lz;
    m      = {mag[30:23] != 8'd0, mag[22:0]};
    lz     = fisq_lzc27({m, 3'b111});
    u.mant = m << lz;
    u.exp  = ((mag[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, mag[30:23]}))
             - $signed({6'd0, lz});
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fast_inverse_sqrt.sv
// Top level: pipelined approximate reciprocal square root of binary32 values.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    in_value_bits[31:0]
//   out_     output     out_valid/out_stall  out_result_bits[31:0]
//
// Each request passes four 3-stage multipliers and one 4-stage adder in series,
// then the output register.
// One request is taken every cycle while the output side keeps up.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// A one-entry skid buffer catches the result that meets a stalled output;
// in_stall is that buffer's full flag, and the whole pipeline holds with it.
`default_nettype none
`include "fast_inverse_sqrt_macros.svh"
module fast_inverse_sqrt import fisq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_value_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_bits
);

  localparam int unsigned MUL_LAT   = 3;
  localparam int unsigned ADD_LAT   = 4;
  localparam int unsigned TAP_A     = MUL_LAT - 1;
  localparam int unsigned TAP_B     = 2 * MUL_LAT - 1;
  localparam int unsigned TAP_R     = 3 * MUL_LAT + ADD_LAT - 1;
  localparam int unsigned LINE_LEN  = TAP_R + 1;

  logic en, take;
  logic [31:0] y0;
  logic [31:0] y_line_r [LINE_LEN];

  logic hv, av, bv, cv, rv;
  logic [31:0] hres, ares, bres, cres, rres;

  logic out_valid_r, skid_full_r;
  logic [31:0] out_bits_r, skid_r;

  assign en   = !skid_full_r;
  assign take = out_valid_r && !out_stall;
  assign y0   = FISQ_MAGIC - {in_value_bits[31], in_value_bits[31:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      y_line_r[0] <= y0;
      for (int i = 1; i < LINE_LEN; i++) begin
        y_line_r[i] <= y_line_r[i-1];
      end
    end
  end

  fisq_fmul u_half (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid && en), .in_a(in_value_bits), .in_b(FISQ_HALF),
    .out_valid(hv), .out_res(hres)
  );

  fisq_fmul u_mul_a (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(hv), .in_a(hres), .in_b(y_line_r[TAP_A]),
    .out_valid(av), .out_res(ares)
  );

  fisq_fmul u_mul_b (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(av), .in_a(ares), .in_b(y_line_r[TAP_B]),
    .out_valid(bv), .out_res(bres)
  );

  fisq_fadd u_sub_c (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(bv), .in_a(FISQ_ONE_HALF), .in_b({~bres[31], bres[30:0]}),
    .out_valid(cv), .out_res(cres)
  );

  fisq_fmul u_mul_r (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(cv), .in_a(y_line_r[TAP_R]), .in_b(cres),
    .out_valid(rv), .out_res(rres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      if (!out_valid_r || take) begin
        out_valid_r <= skid_full_r || (en && rv);
      end
      if (take) begin
        skid_full_r <= 1'b0;
      end else if (out_valid_r && en && rv) begin
        skid_full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_bits_r <= skid_full_r ? skid_r : rres;
    end
    if (!take && out_valid_r && en && rv) begin
      skid_r <= rres;
    end
  end

  assign in_stall        = skid_full_r;
  assign out_valid       = out_valid_r;
  assign out_result_bits = out_bits_r;

  `FISQ_ASSERT_NOW(a_skid_needs_out, skid_full_r, out_valid_r, "skid full with empty output")
  `FISQ_ASSERT_NEXT(a_pipe_hold, (!en && rv), (rv && $stable(rres)), "pipeline moved while held")
  `FISQ_ASSERT_NOW(a_nan_canon, (out_valid_r && out_bits_r[30:23] == FISQ_EXP_MAX && out_bits_r[22:0] != 23'd0), (out_bits_r == FISQ_CANON_NAN), "non-canonical NaN")

endmodule
`default_nettype wire

FILE: rtl/fisq_fmul.sv
// Three-stage binary32 multiplier with round-to-nearest-even and subnormal support.
`default_nettype none
module fisq_fmul import fisq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] in_a,
  input  wire logic [31:0] in_b,
  output logic             out_valid,
  output logic [31:0]      out_res
);

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, nan, inf, zero;
  fisq_unpk_t ua, ub;
  logic [31:0] spec_val;

  logic v1_r, s1_r, spec1_r;
  logic [31:0] specv1_r;
  fisq_unpk_t ua1_r, ub1_r;

  logic v2_r, s2_r, spec2_r;
  logic [31:0] specv2_r;
  logic [47:0] p2_r;
  logic signed [10:0] e2_r;

  logic v3_r;
  logic [31:0] res3_r;

  logic [47:0] pn, shifted, mask;
  logic signed [10:0] e1, t;
  logic [5:0] sh;
  logic [7:0] efield;
  logic g, st, inc;
  logic [31:0] res_nxt;

  always_comb begin
    a_nan  = (in_a[30:23] == FISQ_EXP_MAX) && (in_a[22:0] != 23'd0);
    b_nan  = (in_b[30:23] == FISQ_EXP_MAX) && (in_b[22:0] != 23'd0);
    a_inf  = (in_a[30:23] == FISQ_EXP_MAX) && (in_a[22:0] == 23'd0);
    b_inf  = (in_b[30:23] == FISQ_EXP_MAX) && (in_b[22:0] == 23'd0);
    a_zero = in_a[30:0] == 31'd0;
    b_zero = in_b[30:0] == 31'd0;
    nan    = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    inf    = a_inf | b_inf;
    zero   = a_zero | b_zero;
    if (nan) begin
      spec_val = FISQ_CANON_NAN;
    end else if (inf) begin
      spec_val = {in_a[31] ^ in_b[31], FISQ_EXP_MAX, 23'd0};
    end else begin
      spec_val = {in_a[31] ^ in_b[31], 31'd0};
    end
    ua = fisq_unpack_norm(in_a[30:0]);
    ub = fisq_unpack_norm(in_b[30:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= in_a[31] ^ in_b[31];
      spec1_r  <= nan | inf | zero;
      specv1_r <= spec_val;
      ua1_r    <= ua;
      ub1_r    <= ub;
      s2_r     <= s1_r;
      spec2_r  <= spec1_r;
      specv2_r <= specv1_r;
      p2_r     <= 48'(ua1_r.mant) * 48'(ub1_r.mant);
      e2_r     <= ua1_r.exp + ub1_r.exp - 11'sd127;
      res3_r   <= res_nxt;
    end
  end

  always_comb begin
    if (p2_r[47]) begin
      pn = p2_r;
      e1 = e2_r + 11'sd1;
    end else begin
      pn = p2_r << 1;
      e1 = e2_r;
    end
    t  = 11'sd1 - e1;
    if (e1 > 11'sd0) begin
      sh = 6'd0;
    end else if (t > 11'sd63) begin
      sh = 6'd63;
    end else begin
      sh = t[5:0];
    end
    shifted = pn >> sh;
    mask    = (48'd1 << sh) - 48'd1;
    g       = shifted[23];
    st      = (|shifted[22:0]) | (|(pn & mask));
    efield  = (e1 > 11'sd0) ? e1[7:0] : 8'd0;
    inc     = g & (st | shifted[24]);
    if (spec2_r) begin
      res_nxt = specv2_r;
    end else if (e1 >= 11'sd255) begin
      res_nxt = {s2_r, FISQ_EXP_MAX, 23'd0};
    end else begin
      res_nxt = {s2_r, {efield, shifted[46:24]} + {30'd0, inc}};
    end
  end

  assign out_valid = v3_r;
  assign out_res   = res3_r;

endmodule
`default_nettype wire

FILE: rtl/fisq_fadd.sv
// Four-stage binary32 adder with round-to-nearest-even and subnormal support.
`default_nettype none
module fisq_fadd import fisq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] in_a,
  input  wire logic [31:0] in_b,
  output logic             out_valid,
  output logic [31:0]      out_res
);

  logic a_nan, b_nan, a_inf, b_inf, nan, inf, swap;
  logic [31:0] lo, sm, spec_val;
  logic [7:0] el, es, d;
  logic [4:0] dc;
  logic [26:0] msx, msh, mmask;

  logic v1_r, spec1_r, sl1_r, sub1_r;
  logic [31:0] specv1_r;
  logic [7:0] el1_r;
  logic [26:0] ml1_r, ms1_r;

  logic v2_r, spec2_r, sl2_r, sub2_r;
  logic [31:0] specv2_r;
  logic [7:0] el2_r;
  logic [27:0] sum2_r;

  logic v3_r, spec3_r, sl3_r, sub3_r, zero3_r;
  logic [31:0] specv3_r;
  logic [8:0] e3_r;
  logic [26:0] n3_r;

  logic v4_r;
  logic [31:0] res4_r;

  logic [4:0] lz;
  logic [8:0] lim, shamt, e_nxt;
  logic [26:0] n_nxt;
  logic [7:0] efield;
  logic inc;
  logic [31:0] res_nxt;

  always_comb begin
    a_nan = (in_a[30:23] == FISQ_EXP_MAX) && (in_a[22:0] != 23'd0);
    b_nan = (in_b[30:23] == FISQ_EXP_MAX) && (in_b[22:0] != 23'd0);
    a_inf = (in_a[30:23] == FISQ_EXP_MAX) && (in_a[22:0] == 23'd0);
    b_inf = (in_b[30:23] == FISQ_EXP_MAX) && (in_b[22:0] == 23'd0);
    nan   = a_nan | b_nan | (a_inf & b_inf & (in_a[31] != in_b[31]));
    inf   = a_inf | b_inf;
    if (nan) begin
      spec_val = FISQ_CANON_NAN;
    end else begin
      spec_val = {a_inf ? in_a[31] : in_b[31], FISQ_EXP_MAX, 23'd0};
    end
    swap  = in_b[30:0] > in_a[30:0];
    lo    = swap ? in_b : in_a;
    sm    = swap ? in_a : in_b;
    el    = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
    es    = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d     = el - es;
    dc    = (d > 8'd31) ? 5'd31 : d[4:0];
    msx   = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
    mmask = 27'((32'd1 << dc) - 32'd1);
    msh   = (msx >> dc) | {26'd0, |(msx & mmask)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1_r  <= nan | inf;
      specv1_r <= spec_val;
      sl1_r    <= lo[31];
      sub1_r   <= in_a[31] ^ in_b[31];
      el1_r    <= el;
      ml1_r    <= {lo[30:23] != 8'd0, lo[22:0], 3'b000};
      ms1_r    <= msh;
      spec2_r  <= spec1_r;
      specv2_r <= specv1_r;
      sl2_r    <= sl1_r;
      sub2_r   <= sub1_r;
      el2_r    <= el1_r;
      sum2_r   <= sub1_r ? ({1'b0, ml1_r} - {1'b0, ms1_r}) : ({1'b0, ml1_r} + {1'b0, ms1_r});
      spec3_r  <= spec2_r;
      specv3_r <= specv2_r;
      sl3_r    <= sl2_r;
      sub3_r   <= sub2_r;
      zero3_r  <= sum2_r == 28'd0;
      n3_r     <= n_nxt;
      e3_r     <= e_nxt;
      res4_r   <= res_nxt;
    end
  end

  always_comb begin
    lz  = fisq_lzc27(sum2_r[26:0]);
    lim = {1'b0, el2_r} - 9'd1;
    shamt = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
    if (sum2_r[27]) begin
      n_nxt = {sum2_r[27:2], sum2_r[1] | sum2_r[0]};
      e_nxt = {1'b0, el2_r} + 9'd1;
    end else begin
      n_nxt = sum2_r[26:0] << shamt;
      e_nxt = {1'b0, el2_r} - shamt;
    end
  end

  always_comb begin
    efield = n3_r[26] ? e3_r[7:0] : 8'd0;
    inc    = n3_r[2] & (n3_r[1] | n3_r[0] | n3_r[3]);
    if (spec3_r) begin
      res_nxt = specv3_r;
    end else if (zero3_r) begin
      res_nxt = {sub3_r ? 1'b0 : sl3_r, 31'd0};
    end else if (e3_r >= 9'd255) begin
      res_nxt = {sl3_r, FISQ_EXP_MAX, 23'd0};
    end else begin
      res_nxt = {sl3_r, {efield, n3_r[25:3]} + {30'd0, inc}};
    end
  end

  assign out_valid = v4_r;
  assign out_res   = res4_r;

endmodule
`default_nettype wire
